[sv/assert_macros.svh]
// Assertion helpers shared by the RTL. The clock is clk, the reset rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define CCE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[sv/cce_pkg.sv]
package cce_pkg;

  localparam int NUM_V   = 256;
  localparam int V_W     = 8;
  localparam int CNT_W   = 9;
  localparam int NUM_C   = 16;
  localparam int C_W     = 4;
  localparam int W_W     = 16;
  localparam int PEN_W   = 16;
  localparam int BASE_W  = 40;
  localparam int SCORE_W = 42;
  localparam int CONF_W  = 15;
  localparam int OP_W    = 3;

  localparam logic [OP_W-1:0] OP_ADD_EDGE  = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_WGT   = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_COLOR = 3'd2;
  localparam logic [OP_W-1:0] OP_EVAL_MOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_EVAL_TOT  = 3'd4;

  typedef enum logic [1:0] {RS_A, RS_B, RS_I} rsel_t;
  typedef enum logic [1:0] {CS_A, CS_I, CS_J} csel_t;

  typedef struct packed {
    logic  clr;
    logic  load;
    logic  rd_row;
    logic  wr_row;
    rsel_t row_sel;
    logic  rd_color;
    csel_t color_sel;
    logic  wr_weight;
    logic  wr_color;
    logic  move_init;
    logic  cap_old;
    logic  walk_issue;
    logic  tot_init;
    logic  row_init;
    logic  cap_ci;
    logic  next_i;
    logic  mul;
    logic  acc_base;
    logic  acc_new;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic j_end;
    logic walk_busy;
    logic i_last;
    logic lim_zero;
    logic out_busy;
  } sts_t;

endpackage

[sv/coloring_cost_evaluator_core.sv]
// Coloring cost evaluator: adjacency matrix, vertex colors and color weights
// for a minimum cost chromatic partition local search.
// Input channel (in_*): one transaction per item; in_stall is high while an
// item is in progress. Add edge reads and writes row a, then row b (a self
// loop is skipped); set weight/color writes one entry; unused codes are ignored.
// Evaluate move walks all 256 entries of the vertex's adjacency row and the
// color store, one neighbor per cycle.
// Evaluate total walks row i from i+1 to lim-1 for every i < lim
// (lim = min(vertex_count, 256)); when lim is zero no row is walked.
// The single read port of the color store paces both walks.
// Result channel (out_*): one transaction for each evaluation, held in an
// output register; the next item is taken while a result waits. A stalled
// result holds until taken; a further evaluation then waits in its last step.
// Reset: rst_n (synchronous, active low) clears the adjacency and color stores;
// the input channel stalls until then. Configuration (APB): penalty at 0x0,
// vertex_count at 0x4, written by the user in idle (not enforced by the block).
module coloring_cost_evaluator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [cce_pkg::OP_W-1:0]           in_operation,
  input  logic [cce_pkg::V_W-1:0]            in_vertex_a,
  input  logic [cce_pkg::V_W-1:0]            in_vertex_b,
  input  logic [cce_pkg::C_W-1:0]            in_color,
  input  logic [cce_pkg::W_W-1:0]            in_weight_value,
  input  logic [cce_pkg::BASE_W-1:0]         in_base_score,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cce_pkg::SCORE_W-1:0] out_score,
  output logic [cce_pkg::CONF_W-1:0]         out_conflict_count,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import cce_pkg::*;

  logic [PEN_W-1:0] penalty_r;
  logic [CNT_W-1:0] vcount_r;
  logic             cfg_wr;
  cmd_t             cmd;
  sts_t             sts;
  logic             edge_self;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register select: paddr bit 2 picks vertex_count, otherwise penalty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      penalty_r <= PEN_W'(1);
      vcount_r  <= CNT_W'(NUM_V);
    end else if (cfg_wr) begin
      if (paddr[2]) vcount_r  <= pwdata[CNT_W-1:0];
      else          penalty_r <= pwdata[PEN_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'(vcount_r) : 32'(penalty_r);

  // Sequencer: decodes each transaction and steps the datapath.
  cce_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .edge_self    (edge_self),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  // Stores, walk counters, multiplier, accumulator and output register.
  cce_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .edge_self          (edge_self),
    .in_vertex_a        (in_vertex_a),
    .in_vertex_b        (in_vertex_b),
    .in_color           (in_color),
    .in_weight_value    (in_weight_value),
    .in_base_score      (in_base_score),
    .penalty            (penalty_r),
    .vertex_count       (vcount_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_score          (out_score),
    .out_conflict_count (out_conflict_count)
  );

endmodule

[sv/cce_ctrl.sv]
`include "assert_macros.svh"
module cce_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [cce_pkg::OP_W-1:0] in_operation,
  input  logic                     edge_self,
  output logic                     in_stall,
  output cce_pkg::cmd_t            cmd,
  input  cce_pkg::sts_t            sts
);
  import cce_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_E_RA, S_E_WA, S_E_RB, S_E_WB, S_WGT, S_COL,
    S_M_RD, S_M_OLD, S_M_WALK, S_M_MUL, S_M_ADD,
    S_T_INIT, S_T_RD, S_T_CAP, S_T_WALK, S_T_MUL, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.load = accept;
        if (accept) begin
          unique case (in_operation)
            OP_ADD_EDGE:  state_nxt = edge_self ? S_IDLE : S_E_RA;
            OP_SET_WGT:   state_nxt = S_WGT;
            OP_SET_COLOR: state_nxt = S_COL;
            OP_EVAL_MOVE: state_nxt = S_M_RD;
            OP_EVAL_TOT:  state_nxt = S_T_INIT;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_E_RA: begin
        cmd.rd_row  = 1'b1;
        cmd.row_sel = RS_A;
        state_nxt   = S_E_WA;
      end
      S_E_WA: begin
        cmd.wr_row  = 1'b1;
        cmd.row_sel = RS_A;
        state_nxt   = S_E_RB;
      end
      S_E_RB: begin
        cmd.rd_row  = 1'b1;
        cmd.row_sel = RS_B;
        state_nxt   = S_E_WB;
      end
      S_E_WB: begin
        cmd.wr_row  = 1'b1;
        cmd.row_sel = RS_B;
        state_nxt   = S_IDLE;
      end
      S_WGT: begin
        cmd.wr_weight = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_COL: begin
        cmd.wr_color = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_M_RD: begin
        cmd.rd_row    = 1'b1;
        cmd.row_sel   = RS_A;
        cmd.rd_color  = 1'b1;
        cmd.color_sel = CS_A;
        cmd.move_init = 1'b1;
        state_nxt     = S_M_OLD;
      end
      S_M_OLD: begin
        cmd.cap_old = 1'b1;
        state_nxt   = S_M_WALK;
      end
      S_M_WALK: begin
        cmd.walk_issue = !sts.j_end;
        cmd.rd_color   = !sts.j_end;
        cmd.color_sel  = CS_J;
        if (sts.j_end && !sts.walk_busy) state_nxt = S_M_MUL;
      end
      S_M_MUL: begin
        cmd.mul      = 1'b1;
        cmd.acc_base = 1'b1;
        state_nxt    = S_M_ADD;
      end
      S_M_ADD: begin
        cmd.acc_new = 1'b1;
        state_nxt   = S_FIN;
      end
      S_T_INIT: begin
        cmd.tot_init = 1'b1;
        state_nxt    = sts.lim_zero ? S_T_MUL : S_T_RD;
      end
      S_T_RD: begin
        cmd.rd_row    = 1'b1;
        cmd.row_sel   = RS_I;
        cmd.rd_color  = 1'b1;
        cmd.color_sel = CS_I;
        cmd.row_init  = 1'b1;
        state_nxt     = S_T_CAP;
      end
      S_T_CAP: begin
        cmd.cap_ci = 1'b1;
        state_nxt  = S_T_WALK;
      end
      S_T_WALK: begin
        cmd.walk_issue = !sts.j_end;
        cmd.rd_color   = !sts.j_end;
        cmd.color_sel  = CS_J;
        if (sts.j_end && !sts.walk_busy) begin
          cmd.next_i = 1'b1;
          state_nxt  = sts.i_last ? S_T_MUL : S_T_RD;
        end
      end
      S_T_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CCE_ASSERT_NXT(a_stall_after_accept,
                  accept && (in_operation == OP_EVAL_MOVE || in_operation == OP_EVAL_TOT),
                  in_stall)
  `CCE_ASSERT_IMP(a_no_issue_past_end, cmd.walk_issue, !sts.j_end)
  `CCE_ASSERT_IMP(a_load_only_idle, cmd.load, state_r == S_IDLE)

endmodule

[sv/cce_dp.sv]
`include "assert_macros.svh"
module cce_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cce_pkg::cmd_t                      cmd,
  output cce_pkg::sts_t                      sts,
  output logic                               edge_self,
  input  logic [cce_pkg::V_W-1:0]            in_vertex_a,
  input  logic [cce_pkg::V_W-1:0]            in_vertex_b,
  input  logic [cce_pkg::C_W-1:0]            in_color,
  input  logic [cce_pkg::W_W-1:0]            in_weight_value,
  input  logic [cce_pkg::BASE_W-1:0]         in_base_score,
  input  logic [cce_pkg::PEN_W-1:0]          penalty,
  input  logic [cce_pkg::CNT_W-1:0]          vertex_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cce_pkg::SCORE_W-1:0] out_score,
  output logic [cce_pkg::CONF_W-1:0]         out_conflict_count
);
  import cce_pkg::*;

  localparam int MUL_W  = CONF_W + 2;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIFF_W = CNT_W + 1;

  logic [NUM_V-1:0]  adj_mem [NUM_V];
  logic [C_W-1:0]    col_mem [NUM_V];
  logic [W_W-1:0]    wgt_r [NUM_C];

  logic [V_W-1:0]    va_r, vb_r, clr_r;
  logic [C_W-1:0]    col_r, old_r, ci_r, col_q, w_addr;
  logic [W_W-1:0]    wv_r, w_rd;
  logic [BASE_W-1:0] base_r;
  logic [NUM_V-1:0]  row_q, row_wdata;
  logic [V_W-1:0]    row_addr, row_other, col_addr, col_waddr;
  logic [C_W-1:0]    col_wdata;
  logic [CNT_W-1:0]  j_r, jd_r, i_r, lim, j_lim, i_inc;
  logic              walk_v_r, total_r, out_valid_r;
  logic [CNT_W-1:0]  n_old_r, n_new_r;
  logic [CONF_W-1:0] conf_r;
  logic [DIFF_W-1:0] diff;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic [SCORE_W-1:0] acc_r;
  logic               nb_hit;

  assign edge_self = (in_vertex_a == in_vertex_b);

  // Clamp vertex_count to the number of stored vertices.
  assign lim   = vertex_count[CNT_W-1] ? CNT_W'(NUM_V) : vertex_count;
  assign j_lim = total_r ? lim : CNT_W'(NUM_V);
  assign i_inc = i_r + CNT_W'(1);

  assign sts.clr_last  = (clr_r == V_W'(NUM_V - 1));
  assign sts.j_end     = (j_r >= j_lim);
  assign sts.walk_busy = walk_v_r;
  assign sts.i_last    = (i_inc >= lim);
  assign sts.lim_zero  = (lim == '0);
  assign sts.out_busy  = out_valid_r && out_stall;

  always_comb begin
    unique case (cmd.row_sel)
      RS_A:    begin row_addr = va_r; row_other = vb_r; end
      RS_B:    begin row_addr = vb_r; row_other = va_r; end
      default: begin row_addr = i_r[V_W-1:0]; row_other = va_r; end
    endcase
    unique case (cmd.color_sel)
      CS_A:    col_addr = va_r;
      CS_I:    col_addr = i_r[V_W-1:0];
      default: col_addr = j_r[V_W-1:0];
    endcase
    priority if (cmd.cap_ci)   w_addr = col_q;
    else if (cmd.acc_base)     w_addr = old_r;
    else                       w_addr = col_r;
  end

  assign w_rd      = wgt_r[w_addr];
  assign row_wdata = cmd.clr ? '0 : (row_q | (NUM_V'(1) << row_other));
  assign col_waddr = cmd.clr ? clr_r : va_r;
  assign col_wdata = cmd.clr ? '0 : col_r;

  // Adjacency rows: one read, one write per cycle.
  always_ff @(posedge clk) begin
    if (cmd.clr || cmd.wr_row) begin
      adj_mem[cmd.clr ? clr_r : row_addr] <= row_wdata;
    end
    if (cmd.rd_row) begin
      row_q <= adj_mem[row_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr || cmd.wr_color) begin
      col_mem[col_waddr] <= col_wdata;
    end
    if (cmd.rd_color) begin
      col_q <= col_mem[col_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_C; k++) wgt_r[k] <= '0;
    end else if (cmd.wr_weight) begin
      wgt_r[col_r] <= wv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      va_r   <= in_vertex_a;
      vb_r   <= in_vertex_b;
      col_r  <= in_color;
      wv_r   <= in_weight_value;
      base_r <= in_base_score;
    end
  end

  // Neighbor hit for the entry read in the previous cycle.
  assign nb_hit = walk_v_r && row_q[jd_r[V_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      walk_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= 1'b0;
    end else begin
      if (cmd.clr) clr_r <= clr_r + V_W'(1);
      walk_v_r <= cmd.walk_issue;
      if (cmd.move_init)     total_r <= 1'b0;
      else if (cmd.tot_init) total_r <= 1'b1;
      if (cmd.out_load)      out_valid_r <= 1'b1;
      else if (!out_stall)   out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    jd_r <= j_r;
    if (cmd.move_init)       j_r <= '0;
    else if (cmd.row_init)   j_r <= i_inc;
    else if (cmd.walk_issue) j_r <= j_r + CNT_W'(1);

    if (cmd.tot_init)    i_r <= '0;
    else if (cmd.next_i) i_r <= i_inc;

    if (cmd.cap_old) old_r <= col_q;
    if (cmd.cap_ci)  ci_r  <= col_q;

    if (cmd.move_init) begin
      n_old_r <= '0;
      n_new_r <= '0;
    end else if (!total_r && nb_hit && jd_r[V_W-1:0] != va_r) begin
      if (col_q == old_r) n_old_r <= n_old_r + CNT_W'(1);
      if (col_q == col_r) n_new_r <= n_new_r + CNT_W'(1);
    end

    if (cmd.tot_init) conf_r <= '0;
    else if (total_r && nb_hit && col_q == ci_r) conf_r <= conf_r + CONF_W'(1);

    if (cmd.tot_init)      acc_r <= '0;
    else if (cmd.cap_ci)   acc_r <= acc_r + SCORE_W'(w_rd);
    else if (cmd.acc_base) acc_r <= SCORE_W'(base_r) - SCORE_W'(w_rd);
    else if (cmd.acc_new)  acc_r <= acc_r + SCORE_W'(w_rd);

    if (cmd.mul) prod_r <= mul_a * mul_b;

    if (cmd.out_load) begin
      out_score          <= $signed(acc_r + SCORE_W'(prod_r));
      out_conflict_count <= total_r ? conf_r : CONF_W'(n_new_r);
    end
  end

  assign diff  = {1'b0, n_new_r} - {1'b0, n_old_r};
  assign mul_a = total_r ? $signed({2'b00, conf_r})
                         : $signed({{(MUL_W - DIFF_W){diff[DIFF_W-1]}}, diff});
  assign mul_b = $signed({1'b0, penalty});

  assign out_valid = out_valid_r;

  `CCE_ASSERT_IMP(a_no_overwrite, cmd.out_load, !(out_valid_r && out_stall))
  `CCE_ASSERT_IMP(a_walk_in_range, walk_v_r, jd_r < CNT_W'(NUM_V))
  `CCE_ASSERT_NXT(a_move_count_bound, cmd.out_load && !total_r,
                  out_conflict_count < CONF_W'(NUM_V))

endmodule
